@@ sv/dau_pkg.sv @@
// ----------------------------------------------------------------------------
// Decimal arithmetic unit package
// Shared types, codes, constants and helper functions for the scaled-integer
// decimal arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dau_pkg;

    // Format limits
    localparam int unsigned MAX_PRECISION = 38;
    localparam int unsigned MAX_SCALE     = 18;
    // Powers of ten that fit in 64 bits: 10^0 .. 10^18
    localparam int unsigned POW10_ENTRIES = 19;
    // One quotient bit per divider stage
    localparam int unsigned DIV_STEPS     = 64;
    // Command queue between front and back
    localparam int unsigned QUEUE_DEPTH   = 4;
    localparam int unsigned QUEUE_AW      = $clog2(QUEUE_DEPTH);

    localparam logic [63:0] VALUE_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] VALUE_MAX     = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] VALUE_NEG_ONE = 64'hffff_ffff_ffff_ffff;

    // Operation codes on the input port
    localparam logic [2:0] FUNC_ADD  = 3'd0;
    localparam logic [2:0] FUNC_SUB  = 3'd1;
    localparam logic [2:0] FUNC_MUL  = 3'd2;
    localparam logic [2:0] FUNC_DIV  = 3'd3;
    localparam logic [2:0] FUNC_MOD  = 3'd4;
    localparam logic [2:0] FUNC_NEG  = 3'd5;
    localparam logic [2:0] FUNC_CMP  = 3'd6;
    localparam logic [2:0] FUNC_RSVD = 3'd7;

    // Internal operation after classification; OP_BAD covers bad formats
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_NEG = 3'd5,
        OP_CMP = 3'd6,
        OP_BAD = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_INVALID  = 2'd3
    } status_t;

    // Input transaction
    typedef struct packed {
        logic [2:0]         func;
        logic signed [63:0] first_value;
        logic [5:0]         first_precision;
        logic [4:0]         first_scale;
        logic signed [63:0] second_value;
        logic [5:0]         second_precision;
        logic [4:0]         second_scale;
    } dau_in_t;

    // Result transaction
    typedef struct packed {
        logic signed [63:0] res_value;
        logic [6:0]         res_prec;
        logic [5:0]         res_scale;
        logic [1:0]         status;
        logic               is_less;
        logic               is_equal;
    } dau_out_t;

    // Classified command from the front to the back
    typedef struct packed {
        op_t         op;
        logic [6:0]  rp;
        logic [5:0]  rs;
        logic [63:0] mul_a;
        logic [63:0] mul_b;
        logic [63:0] other;
        logic        swap;
    } dau_cmd_t;

    // Sideband carried along the divider
    typedef struct packed {
        op_t         op;
        logic [6:0]  rp;
        logic [5:0]  rs;
        status_t     st;
        logic [63:0] val;
        logic        lt;
        logic        eq;
        logic        sgn;
    } dau_tail_t;

    function automatic logic [63:0] pow10(input logic [4:0] idx);
        logic [63:0] p;
        case (idx)
            5'd0:    p = 64'd1;
            5'd1:    p = 64'd10;
            5'd2:    p = 64'd100;
            5'd3:    p = 64'd1000;
            5'd4:    p = 64'd10000;
            5'd5:    p = 64'd100000;
            5'd6:    p = 64'd1000000;
            5'd7:    p = 64'd10000000;
            5'd8:    p = 64'd100000000;
            5'd9:    p = 64'd1000000000;
            5'd10:   p = 64'd10000000000;
            5'd11:   p = 64'd100000000000;
            5'd12:   p = 64'd1000000000000;
            5'd13:   p = 64'd10000000000000;
            5'd14:   p = 64'd100000000000000;
            5'd15:   p = 64'd1000000000000000;
            5'd16:   p = 64'd10000000000000000;
            5'd17:   p = 64'd100000000000000000;
            default: p = 64'd1000000000000000000;
        endcase
        return p;
    endfunction

    // Magnitude of a two's complement word, as unsigned
    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    // Magnitude fits d digits; wide bounds always pass
    function automatic logic in_range(input logic [63:0] m, input logic [6:0] d);
        logic ok;
        if (d >= 7'(POW10_ENTRIES))
            ok = 1'b1;
        else
            ok = (m < pow10(d[4:0]));
        return ok;
    endfunction

    function automatic logic valid_fmt(input logic [5:0] p, input logic [4:0] s);
        return (p >= 6'd1) && (p <= 6'(MAX_PRECISION)) &&
               (s <= 5'(MAX_SCALE)) && ({1'b0, s} <= p);
    endfunction

endpackage

`default_nettype wire

@@ sv/dau_front.sv @@
// ----------------------------------------------------------------------------
// Decimal arithmetic unit front end
// Checks operand formats, decodes the operation, picks the multiplier
// operands for scale alignment and queues the command for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dau_front
    import dau_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire dau_in_t  operand,
    input  wire logic     take,
    output logic          cmd_valid,
    output dau_cmd_t      cmd
);

    dau_cmd_t              q_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;

    dau_cmd_t    cls;
    logic        va, vb, bad, swap;
    logic [5:0]  pm;
    logic [4:0]  sc;
    logic [63:0] align_f, a, b;
    logic        push_ok, pop_ok;

    // Classify the incoming transaction
    always_comb
    begin
        a    = operand.first_value;
        b    = operand.second_value;
        va   = valid_fmt(operand.first_precision, operand.first_scale);
        vb   = valid_fmt(operand.second_precision, operand.second_scale);
        pm   = (operand.first_precision > operand.second_precision) ?
               operand.first_precision : operand.second_precision;
        sc   = (operand.first_scale > operand.second_scale) ?
               operand.first_scale : operand.second_scale;
        swap = (operand.first_scale >= operand.second_scale);
        align_f = swap ? pow10(operand.first_scale - operand.second_scale)
                       : pow10(operand.second_scale - operand.first_scale);
        bad  = !va || ((operand.func != FUNC_NEG) && !vb);

        // aligned form: the operand with the smaller scale is scaled up
        cls.op    = OP_BAD;
        cls.rp    = '0;
        cls.rs    = '0;
        cls.mul_a = swap ? b : a;
        cls.mul_b = align_f;
        cls.other = swap ? a : b;
        cls.swap  = swap;

        unique case (operand.func) inside
            FUNC_ADD, FUNC_SUB, FUNC_MOD:
            begin
                cls.op = (operand.func == FUNC_ADD) ? OP_ADD :
                         (operand.func == FUNC_SUB) ? OP_SUB : OP_MOD;
                cls.rp = {1'b0, pm};
                cls.rs = {1'b0, sc};
            end
            FUNC_MUL:
            begin
                cls.op    = OP_MUL;
                cls.rp    = 7'(operand.first_precision) + 7'(operand.second_precision);
                cls.rs    = 6'(operand.first_scale) + 6'(operand.second_scale);
                cls.mul_a = a;
                cls.mul_b = b;
                cls.other = b;
            end
            FUNC_DIV:
            begin
                cls.op    = OP_DIV;
                cls.rp    = {1'b0, operand.first_precision};
                cls.rs    = {1'b0, operand.first_scale};
                cls.mul_a = a;
                cls.mul_b = pow10(operand.second_scale);
                cls.other = b;
            end
            FUNC_NEG:
            begin
                cls.op    = OP_NEG;
                cls.rp    = {1'b0, operand.first_precision};
                cls.rs    = {1'b0, operand.first_scale};
                cls.mul_a = a;
                cls.mul_b = 64'd1;
                cls.other = b;
            end
            FUNC_CMP:
            begin
                cls.op = OP_CMP;
            end
            default:
            begin
                cls.op = OP_BAD;
            end
        endcase

        // drop format on invalid operands
        if (bad)
        begin
            cls.op = OP_BAD;
            cls.rp = '0;
            cls.rs = '0;
        end
    end

    // Queue control
    always_comb
    begin
        full        = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
        cmd_valid   = (count_reg != '0);
        push_ok     = push && !full;
        pop_ok      = take && cmd_valid;
        wr_ptr_next = push_ok ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok && !pop_ok)
            count_next = count_reg + 1'b1;
        else if (!push_ok && pop_ok)
            count_next = count_reg - 1'b1;
        cmd = q_reg[rd_ptr_reg];
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (push_ok)
            q_reg[wr_ptr_reg] <= cls;
    end

endmodule

`default_nettype wire

@@ sv/dau_mul.sv @@
// ----------------------------------------------------------------------------
// Decimal arithmetic unit multiplier
// Five-stage signed 64x64 multiplier built from 32x32 partial products,
// with a signed 64-bit overflow flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dau_mul
    import dau_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire logic      in_valid,
    input  wire dau_cmd_t  in_cmd,
    output logic           out_valid,
    output logic [63:0]    out_prod,
    output logic           out_ovf,
    output dau_cmd_t       out_cmd
);

    logic         v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    dau_cmd_t     c0_reg, c1_reg, c2_reg, c3_reg, c4_reg;
    logic         neg0_reg, neg1_reg, neg2_reg, neg3_reg;
    logic [63:0]  ua0_reg, ub0_reg;
    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0] lohi_reg;
    logic [64:0]  mid_reg;
    logic [127:0] prod3_reg;
    logic [127:0] prod3_next;
    logic [63:0]  prod4_reg, prod4_next, lim;
    logic         ovf4_reg, ovf4_next;

    // Combine partial products and check the signed range
    always_comb
    begin
        prod3_next = lohi_reg + {31'b0, mid_reg, 32'b0};
        lim        = neg3_reg ? VALUE_MIN : VALUE_MAX;
        ovf4_next  = (prod3_reg[127:64] != '0) || (prod3_reg[63:0] > lim);
        prod4_next = neg3_reg ? (~prod3_reg[63:0] + 64'd1) : prod3_reg[63:0];
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_reg    <= in_cmd;
            ua0_reg   <= mag64(in_cmd.mul_a);
            ub0_reg   <= mag64(in_cmd.mul_b);
            neg0_reg  <= in_cmd.mul_a[63] ^ in_cmd.mul_b[63];

            c1_reg    <= c0_reg;
            neg1_reg  <= neg0_reg;
            p00_reg   <= ua0_reg[31:0]  * ub0_reg[31:0];
            p01_reg   <= ua0_reg[31:0]  * ub0_reg[63:32];
            p10_reg   <= ua0_reg[63:32] * ub0_reg[31:0];
            p11_reg   <= ua0_reg[63:32] * ub0_reg[63:32];

            c2_reg    <= c1_reg;
            neg2_reg  <= neg1_reg;
            lohi_reg  <= {p11_reg, p00_reg};
            mid_reg   <= {1'b0, p01_reg} + {1'b0, p10_reg};

            c3_reg    <= c2_reg;
            neg3_reg  <= neg2_reg;
            prod3_reg <= prod3_next;

            c4_reg    <= c3_reg;
            prod4_reg <= prod4_next;
            ovf4_reg  <= ovf4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_prod  = prod4_reg;
    assign out_ovf   = ovf4_reg;
    assign out_cmd   = c4_reg;

endmodule

`default_nettype wire

@@ sv/dau_div.sv @@
// ----------------------------------------------------------------------------
// Decimal arithmetic unit divider
// Pipelined restoring divider, one quotient bit per stage, giving unsigned
// quotient and remainder with the sideband carried alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dau_div
    import dau_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  wire logic [63:0] in_dvd,
    input  wire logic [63:0] in_dvs,
    input  wire dau_tail_t  in_tail,
    output logic            out_valid,
    output logic [63:0]     out_quo,
    output logic [63:0]     out_rem,
    output dau_tail_t       out_tail
);

    logic        valid_reg [DIV_STEPS];
    logic [63:0] rem_reg   [DIV_STEPS];
    logic [63:0] dq_reg    [DIV_STEPS];
    logic [63:0] dvs_reg   [DIV_STEPS];
    dau_tail_t   tail_reg  [DIV_STEPS];

    logic        valid_src [DIV_STEPS];
    logic [63:0] rem_src   [DIV_STEPS];
    logic [63:0] dq_src    [DIV_STEPS];
    logic [63:0] dvs_src   [DIV_STEPS];
    dau_tail_t   tail_src  [DIV_STEPS];

    logic [63:0] rem_next  [DIV_STEPS];
    logic [63:0] dq_next   [DIV_STEPS];

    // Select each stage's source
    always_comb
    begin
        valid_src[0] = in_valid;
        rem_src[0]   = '0;
        dq_src[0]    = in_dvd;
        dvs_src[0]   = in_dvs;
        tail_src[0]  = in_tail;
        for (int i = 1; i < DIV_STEPS; i++)
        begin
            valid_src[i] = valid_reg[i-1];
            rem_src[i]   = rem_reg[i-1];
            dq_src[i]    = dq_reg[i-1];
            dvs_src[i]   = dvs_reg[i-1];
            tail_src[i]  = tail_reg[i-1];
        end
    end

    // Shift in one dividend bit and subtract when it fits
    always_comb
    begin
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            logic [64:0] t;
            logic        ge;
            t  = {rem_src[i], dq_src[i][63]};
            ge = (t >= {1'b0, dvs_src[i]});
            rem_next[i] = ge ? 64'(t - {1'b0, dvs_src[i]}) : t[63:0];
            dq_next[i]  = {dq_src[i][62:0], ge};
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STEPS; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            for (int i = 0; i < DIV_STEPS; i++)
                valid_reg[i] <= valid_src[i];
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                dq_reg[i]   <= dq_next[i];
                dvs_reg[i]  <= dvs_src[i];
                tail_reg[i] <= tail_src[i];
            end
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign out_quo   = dq_reg[DIV_STEPS-1];
    assign out_rem   = rem_reg[DIV_STEPS-1];
    assign out_tail  = tail_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

@@ sv/dau_back.sv @@
// ----------------------------------------------------------------------------
// Decimal arithmetic unit back end
// Runs multiply, add, subtract, compare, negate, divide and modulo on queued commands,
// checks ranges and holds the finished result for the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dau_back
    import dau_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    input  wire dau_cmd_t  cmd,
    output logic           take,
    output logic           empty,
    input  wire logic      pop,
    output dau_out_t       result
);

    logic        en;
    logic        m_valid, m_ovf;
    logic [63:0] m_prod;
    dau_cmd_t    m_cmd;

    // execute stage
    logic        ex_valid_reg;
    op_t         ex_op_reg;
    logic [6:0]  ex_rp_reg;
    logic [5:0]  ex_rs_reg;
    status_t     ex_st_reg, ex_st_next;
    logic [63:0] ex_r_reg, ex_r_next;
    logic [63:0] ex_x_reg, ex_y_reg;
    logic        ex_lt_reg, ex_eq_reg;
    logic [63:0] x, y, sum, dif;
    logic        aligned, ovf_add, ovf_sub;

    // magnitude stage
    logic        mg_valid_reg;
    op_t         mg_op_reg;
    logic [6:0]  mg_rp_reg;
    logic [5:0]  mg_rs_reg;
    status_t     mg_st_reg;
    logic [63:0] mg_r_reg, mg_mr_reg, mg_dvd_reg, mg_dvs_reg;
    logic        mg_lt_reg, mg_eq_reg, mg_sgn_reg;
    dau_tail_t   tail;

    logic        d_valid;
    logic [63:0] d_quo, d_rem;
    dau_tail_t   d_tail;

    logic        out_valid_reg;
    dau_out_t    out_reg, out_next;

    // Stall the whole pipe while a result waits
    assign en    = !out_valid_reg || pop;
    assign take  = en;
    assign empty = !out_valid_reg;

    dau_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cmd_valid),
        .in_cmd    (cmd),
        .out_valid (m_valid),
        .out_prod  (m_prod),
        .out_ovf   (m_ovf),
        .out_cmd   (m_cmd)
    );

    // Execute: place the aligned operand, add, subtract, compare, negate
    always_comb
    begin
        aligned = (m_cmd.op == OP_ADD) || (m_cmd.op == OP_SUB) ||
                  (m_cmd.op == OP_MOD) || (m_cmd.op == OP_CMP);
        x   = (aligned && m_cmd.swap) ? m_cmd.other : m_prod;
        y   = (aligned && m_cmd.swap) ? m_prod : m_cmd.other;
        sum = x + y;
        dif = x - y;
        ovf_add = (~(x[63] ^ y[63])) & (x[63] ^ sum[63]);
        ovf_sub = (x[63] ^ y[63]) & (x[63] ^ dif[63]);

        ex_r_next  = x;
        ex_st_next = ST_OK;
        unique case (m_cmd.op) inside
            OP_ADD:
            begin
                ex_r_next  = sum;
                ex_st_next = (m_ovf || ovf_add) ? ST_OVERFLOW : ST_OK;
            end
            OP_SUB:
            begin
                ex_r_next  = dif;
                ex_st_next = (m_ovf || ovf_sub) ? ST_OVERFLOW : ST_OK;
            end
            OP_MUL, OP_CMP:
            begin
                ex_st_next = m_ovf ? ST_OVERFLOW : ST_OK;
            end
            OP_DIV:
            begin
                if (y == '0)
                    ex_st_next = ST_DIV_ZERO;
                else if (m_ovf || ((x == VALUE_MIN) && (y == VALUE_NEG_ONE)))
                    ex_st_next = ST_OVERFLOW;
            end
            OP_MOD:
            begin
                // a scaled divisor that wrapped to zero was not zero at the input
                if ((y == '0) && !(m_cmd.swap && m_ovf))
                    ex_st_next = ST_DIV_ZERO;
                else if (m_ovf)
                    ex_st_next = ST_OVERFLOW;
            end
            OP_NEG:
            begin
                ex_r_next  = ~x + 64'd1;
                ex_st_next = (x == VALUE_MIN) ? ST_OVERFLOW : ST_OK;
            end
            default:
            begin
                ex_st_next = ST_INVALID;
            end
        endcase
    end

    // Range check and sideband for the divider
    always_comb
    begin
        tail.op  = mg_op_reg;
        tail.rp  = mg_rp_reg;
        tail.rs  = mg_rs_reg;
        tail.st  = mg_st_reg;
        tail.sgn = mg_sgn_reg;
        if ((mg_st_reg == ST_OK) &&
            ((mg_op_reg == OP_ADD) || (mg_op_reg == OP_SUB) || (mg_op_reg == OP_MUL)) &&
            !in_range(mg_mr_reg, mg_rp_reg))
            tail.st = ST_OVERFLOW;
        else if ((mg_st_reg == ST_OK) && (mg_op_reg == OP_MUL) &&
                 ((mg_rp_reg > 7'(MAX_PRECISION)) || (mg_rs_reg > 6'(MAX_SCALE))))
            tail.st = ST_INVALID;
        tail.val = ((tail.st == ST_OK) &&
                    ((mg_op_reg == OP_ADD) || (mg_op_reg == OP_SUB) ||
                     (mg_op_reg == OP_MUL) || (mg_op_reg == OP_NEG))) ? mg_r_reg : '0;
        tail.lt  = (mg_op_reg == OP_CMP) && (tail.st == ST_OK) && mg_lt_reg;
        tail.eq  = (mg_op_reg == OP_CMP) && (tail.st == ST_OK) && mg_eq_reg;
    end

    dau_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mg_valid_reg),
        .in_dvd    (mg_dvd_reg),
        .in_dvs    (mg_dvs_reg),
        .in_tail   (tail),
        .out_valid (d_valid),
        .out_quo   (d_quo),
        .out_rem   (d_rem),
        .out_tail  (d_tail)
    );

    // Finish divide and modulo, build the result transaction
    always_comb
    begin
        out_next.res_value = d_tail.val;
        out_next.res_prec  = d_tail.rp;
        out_next.res_scale = d_tail.rs;
        out_next.status    = d_tail.st;
        out_next.is_less   = d_tail.lt;
        out_next.is_equal  = d_tail.eq;
        if ((d_tail.op == OP_DIV) && (d_tail.st == ST_OK))
        begin
            if (in_range(d_quo, d_tail.rp))
                out_next.res_value = d_tail.sgn ? (~d_quo + 64'd1) : d_quo;
            else
                out_next.status = ST_OVERFLOW;
        end
        else if ((d_tail.op == OP_MOD) && (d_tail.st == ST_OK))
        begin
            out_next.res_value = d_tail.sgn ? (~d_rem + 64'd1) : d_rem;
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg  <= 1'b0;
            mg_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ex_valid_reg  <= m_valid;
            mg_valid_reg  <= ex_valid_reg;
            out_valid_reg <= d_valid;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ex_op_reg  <= m_cmd.op;
            ex_rp_reg  <= m_cmd.rp;
            ex_rs_reg  <= m_cmd.rs;
            ex_st_reg  <= ex_st_next;
            ex_r_reg   <= ex_r_next;
            ex_x_reg   <= x;
            ex_y_reg   <= y;
            ex_lt_reg  <= $signed(x) < $signed(y);
            ex_eq_reg  <= (x == y);

            mg_op_reg  <= ex_op_reg;
            mg_rp_reg  <= ex_rp_reg;
            mg_rs_reg  <= ex_rs_reg;
            mg_st_reg  <= ex_st_reg;
            mg_r_reg   <= ex_r_reg;
            mg_mr_reg  <= mag64(ex_r_reg);
            mg_dvd_reg <= mag64(ex_x_reg);
            mg_dvs_reg <= mag64(ex_y_reg);
            mg_lt_reg  <= ex_lt_reg;
            mg_eq_reg  <= ex_eq_reg;
            mg_sgn_reg <= (ex_op_reg == OP_DIV) ? (ex_x_reg[63] ^ ex_y_reg[63])
                                                : ex_x_reg[63];

            out_reg    <= out_next;
        end
    end

    assign result = out_reg;

endmodule

`default_nettype wire

@@ sv/decimal_arith_unit_core.sv @@
// ----------------------------------------------------------------------------
// Decimal arithmetic unit
// Scaled-integer decimal add, subtract, multiply, divide, modulo, negate and
// compare on 64-bit values with precision and scale.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive operand and raise push; a transaction is taken at a
//   clock edge with push high and full low. Result channel: while empty is
//   low the oldest result sits on result; raise pop to take it.
//   Every transaction gives exactly one result, in order.
//   The command enters the multiplier from the queue, then passes in order
//   through the five multiplier stages, the two execute and range stages,
//   the 64 divider stages and the output register.
//   Throughput: one transaction per cycle on both sides while no held result
//   stalls the pipe; the pipelined multiplier and the bit-per-stage divider
//   each take a new operand pair every cycle unless the pipe is stalled.
//   Reset clears the command queue and all valid bits; no result is shown.
//   When the receiver holds off pop, the back end freezes in place and the
//   four-entry front queue keeps taking transactions until it fills, then
//   full rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module decimal_arith_unit_core
    import dau_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire dau_in_t  operand,
    output logic          empty,
    input  wire logic     pop,
    output dau_out_t      result
);

    logic     cmd_valid;
    logic     take;
    dau_cmd_t cmd;

    dau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .operand   (operand),
        .take      (take),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    dau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .take      (take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Decimal arithmetic unit testbench
// Drives operand transactions through the push/full queue interface, predicts
// each result with an independent scaled-integer model unless a directed row
// gives it typed in, and compares every popped result field by field. Directed
// rows cover extremes, every operation and the error cases; random ones follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
    import dau_pkg::*;
();

    localparam int LATENCY    = 72;
    localparam int CYCLE_CAP  = 400000;
    localparam int RAND_ITEMS = 900;

    logic     clk;
    logic     rst_n;
    logic     push;
    logic     full;
    dau_in_t  operand;
    logic     empty;
    logic     pop;
    dau_out_t result;

    decimal_arith_unit_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .operand (operand),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    dau_out_t    pending_results[$];
    int          error_count;
    int unsigned cycle_count;

    // Generate clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Count cycles and stop on timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    function automatic logic [63:0] abs64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] ten_to(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n && i < 18; i++)
            p = p * 64'd10;
        return p;
    endfunction

    function automatic logic fmt_ok(input logic [5:0] p, input logic [4:0] s);
        return p >= 1 && p <= MAX_PRECISION && s <= MAX_SCALE && s <= p;
    endfunction

    // Signed product with overflow detection
    function automatic logic smul(input logic [63:0] a, input logic [63:0] b,
                                  output logic [63:0] r);
        logic [127:0] full_prod;
        logic         neg;
        logic [63:0]  lim;
        neg = a[63] ^ b[63];
        lim = neg ? VALUE_MIN : VALUE_MAX;
        full_prod = abs64(a) * abs64(b);
        r = neg ? (64'd0 - full_prod[63:0]) : full_prod[63:0];
        return full_prod <= {64'd0, lim};
    endfunction

    function automatic logic rescale(input logic [63:0] v, input int from,
                                     input int to, output logic [63:0] r);
        if (to <= from)
        begin
            r = v;
            return 1'b1;
        end
        return smul(v, ten_to(to - from), r);
    endfunction

    function automatic logic fits(input logic [63:0] v, input int p, input int s);
        int d;
        d = p > s ? p : s;
        if (d == 0)
            return v == 0;
        if (d >= 19)
            return 1'b1;
        return abs64(v) <= ten_to(d) - 1;
    endfunction

    // Predict the result of one transaction
    function automatic dau_out_t decimal_result(input dau_in_t t);
        dau_out_t    o;
        logic [63:0] a, b, x, y, r, q;
        int          pa, sa, pb, sb, sc, pm;
        o = '0;
        a = t.first_value;
        b = t.second_value;
        pa = t.first_precision;
        sa = t.first_scale;
        pb = t.second_precision;
        sb = t.second_scale;
        sc = sa > sb ? sa : sb;
        pm = pa > pb ? pa : pb;
        if (t.func > FUNC_CMP || !fmt_ok(t.first_precision, t.first_scale) ||
            (t.func != FUNC_NEG && !fmt_ok(t.second_precision, t.second_scale)))
        begin
            o.status = ST_INVALID;
        end
        else if (t.func == FUNC_ADD || t.func == FUNC_SUB)
        begin
            o.res_prec = 7'(pm);
            o.res_scale = 6'(sc);
            if (!rescale(a, sa, sc, x) || !rescale(b, sb, sc, y))
                o.status = ST_OVERFLOW;
            else
            begin
                if (t.func == FUNC_ADD)
                begin
                    r = x + y;
                    if ((~(x ^ y) & (x ^ r)) & VALUE_MIN)
                        o.status = ST_OVERFLOW;
                end
                else
                begin
                    r = x - y;
                    if (((x ^ y) & (x ^ r)) & VALUE_MIN)
                        o.status = ST_OVERFLOW;
                end
                if (o.status == ST_OK && !fits(r, pm, sc))
                    o.status = ST_OVERFLOW;
                if (o.status == ST_OK)
                    o.res_value = r;
            end
        end
        else if (t.func == FUNC_MUL)
        begin
            o.res_prec = 7'(pa + pb);
            o.res_scale = 6'(sa + sb);
            if (!smul(a, b, r) || !fits(r, pa + pb, sa + sb))
                o.status = ST_OVERFLOW;
            else if (pa + pb > MAX_PRECISION || sa + sb > MAX_SCALE)
                o.status = ST_INVALID;
            else
                o.res_value = r;
        end
        else if (t.func == FUNC_DIV)
        begin
            o.res_prec = 7'(pa);
            o.res_scale = 6'(sa);
            if (b == 0)
                o.status = ST_DIV_ZERO;
            else if (!smul(a, ten_to(sb), x))
                o.status = ST_OVERFLOW;
            else if (x == VALUE_MIN && b == VALUE_NEG_ONE)
                o.status = ST_OVERFLOW;
            else
            begin
                q = abs64(x) / abs64(b);
                r = (x[63] ^ b[63]) ? (64'd0 - q) : q;
                if (!fits(r, pa, sa))
                    o.status = ST_OVERFLOW;
                else
                    o.res_value = r;
            end
        end
        else if (t.func == FUNC_MOD)
        begin
            o.res_prec = 7'(pm);
            o.res_scale = 6'(sc);
            if (b == 0)
                o.status = ST_DIV_ZERO;
            else if (!rescale(a, sa, sc, x) || !rescale(b, sb, sc, y))
                o.status = ST_OVERFLOW;
            else
            begin
                q = abs64(x) % abs64(y);
                o.res_value = x[63] ? (64'd0 - q) : q;
            end
        end
        else if (t.func == FUNC_NEG)
        begin
            o.res_prec = 7'(pa);
            o.res_scale = 6'(sa);
            if (a == VALUE_MIN)
                o.status = ST_OVERFLOW;
            else
                o.res_value = 64'd0 - a;
        end
        else
        begin
            if (!rescale(a, sa, sc, x) || !rescale(b, sb, sc, y))
                o.status = ST_OVERFLOW;
            else
            begin
                o.is_less = $signed(x) < $signed(y);
                o.is_equal = x == y;
            end
        end
        return o;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0: v = {$urandom, $urandom};
            1: v = VALUE_MIN + 64'($urandom_range(0, 2));
            2: v = VALUE_MAX - 64'($urandom_range(0, 2));
            3: v = 64'($signed($urandom_range(0, 20)) - 10);
            default:
            begin
                v = 64'($urandom) % ten_to($urandom_range(1, 12));
                if ($urandom_range(0, 1))
                    v = 64'd0 - v;
            end
        endcase
        return v;
    endfunction

    function automatic dau_in_t random_item();
        dau_in_t t;
        t.func = ($urandom_range(0, 40) == 0) ? FUNC_RSVD : 3'($urandom_range(0, 6));
        t.first_value = rand64();
        t.second_value = rand64();
        if ($urandom_range(0, 15) == 0)
        begin
            // raw format fields, mostly invalid
            t.first_precision = 6'($urandom);
            t.first_scale = 5'($urandom);
            t.second_precision = 6'($urandom);
            t.second_scale = 5'($urandom);
        end
        else
        begin
            t.first_precision = 6'($urandom_range(1, 38));
            t.first_scale = 5'($urandom_range(0, t.first_precision < 18 ?
                                              t.first_precision : 18));
            t.second_precision = 6'($urandom_range(1, 38));
            t.second_scale = 5'($urandom_range(0, t.second_precision < 18 ?
                                               t.second_precision : 18));
        end
        return t;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50)
            return 0;
        if (k < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Hold one transaction on the input until accepted
    task automatic send_item(input dau_in_t t, input logic use_given,
                             input dau_out_t given);
        int idle;
        idle = gap_len();
        if (idle > 0)
        begin
            push <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        push <= 1'b1;
        operand <= t;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_results.push_back(use_given ? given : decimal_result(t));
    endtask

    // Pop results with random stalls and check
    always @(posedge clk)
    begin
        dau_out_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", result.res_value, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.res_value !== want.res_value)
                    report_mismatch("value", result.res_value, want.res_value);
                if (result.res_prec !== want.res_prec)
                    report_mismatch("precision", 64'(result.res_prec),
                                    64'(want.res_prec));
                if (result.res_scale !== want.res_scale)
                    report_mismatch("scale", 64'(result.res_scale),
                                    64'(want.res_scale));
                if (result.status !== want.status)
                    report_mismatch("status", 64'(result.status), 64'(want.status));
                if (result.is_less !== want.is_less)
                    report_mismatch("is_less", 64'(result.is_less), 64'(want.is_less));
                if (result.is_equal !== want.is_equal)
                    report_mismatch("is_equal", 64'(result.is_equal),
                                    64'(want.is_equal));
            end
        end
    end

    int stall_left;
    logic stall_phase;

    // Vary pop pressure, with long runs of no stalls
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            pop <= 1'b0;
        end
        else if (stall_phase && $urandom_range(0, 3) == 0)
        begin
            stall_left <= gap_len();
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    typedef struct {
        dau_in_t  item;
        logic     typed_in;
        dau_out_t want;
    } stim_row_t;

    stim_row_t directed[$];

    function automatic dau_in_t mk(input logic [2:0] f, input logic [63:0] a,
                                   input int pa, input int sa, input logic [63:0] b,
                                   input int pb, input int sb);
        dau_in_t t;
        t.func = f;
        t.first_value = a;
        t.first_precision = 6'(pa);
        t.first_scale = 5'(sa);
        t.second_value = b;
        t.second_precision = 6'(pb);
        t.second_scale = 5'(sb);
        return t;
    endfunction

    function automatic dau_out_t res(input logic [63:0] v, input int p, input int s,
                                     input status_t st);
        dau_out_t o;
        o = '0;
        o.res_value = v;
        o.res_prec = 7'(p);
        o.res_scale = 6'(s);
        o.status = st;
        return o;
    endfunction

    task automatic add_row(input dau_in_t t, input logic typed_in, input dau_out_t w);
        stim_row_t row;
        row.item = t;
        row.typed_in = typed_in;
        row.want = w;
        directed.push_back(row);
    endtask

    initial
    begin
        int drain;
        error_count = 0;
        cycle_count = 0;
        stall_phase = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        operand = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: typed-in where obvious, else predicted
        add_row(mk(FUNC_ADD, 64'd15, 4, 1, 64'd25, 5, 2), 1'b1,
                res(64'd175, 5, 2, ST_OK));
        add_row(mk(FUNC_SUB, 64'd1, 2, 0, 64'd3, 2, 0), 1'b1,
                res(-64'sd2, 2, 0, ST_OK));
        add_row(mk(FUNC_MUL, 64'd12, 2, 1, 64'd3, 1, 0), 1'b1,
                res(64'd36, 3, 1, ST_OK));
        add_row(mk(FUNC_DIV, 64'd100, 5, 2, 64'd0, 3, 0), 1'b1,
                res(0, 5, 2, ST_DIV_ZERO));
        add_row(mk(FUNC_MOD, 64'd7, 3, 0, 64'd0, 3, 0), 1'b1,
                res(0, 3, 0, ST_DIV_ZERO));
        add_row(mk(FUNC_NEG, VALUE_MIN, 38, 18, 0, 0, 0), 1'b1,
                res(0, 38, 18, ST_OVERFLOW));
        add_row(mk(FUNC_NEG, VALUE_MAX, 38, 0, 0, 0, 31), 1'b0, '0);
        add_row(mk(FUNC_RSVD, 64'd1, 5, 0, 64'd1, 5, 0), 1'b1,
                res(0, 0, 0, ST_INVALID));
        add_row(mk(FUNC_ADD, 64'd1, 0, 0, 64'd1, 5, 0), 1'b1, res(0, 0, 0, ST_INVALID));
        add_row(mk(FUNC_ADD, 64'd1, 39, 0, 64'd1, 5, 0), 1'b1,
                res(0, 0, 0, ST_INVALID));
        add_row(mk(FUNC_SUB, 64'd1, 20, 19, 64'd1, 5, 0), 1'b1,
                res(0, 0, 0, ST_INVALID));
        add_row(mk(FUNC_CMP, 64'd1, 5, 0, 64'd1, 3, 4), 1'b1,
                res(0, 0, 0, ST_INVALID));
        add_row(mk(FUNC_MUL, 64'd2, 30, 10, 64'd3, 20, 10), 1'b1,
                res(0, 50, 20, ST_INVALID));
        add_row(mk(FUNC_DIV, VALUE_MIN, 38, 0, VALUE_NEG_ONE, 5, 0), 1'b1,
                res(0, 38, 0, ST_OVERFLOW));
        add_row(mk(FUNC_MOD, VALUE_MIN, 38, 0, VALUE_NEG_ONE, 5, 0), 1'b1,
                res(0, 38, 0, ST_OK));
        add_row(mk(FUNC_ADD, VALUE_MAX, 38, 0, 64'd1, 1, 0), 1'b1,
                res(0, 38, 0, ST_OVERFLOW));
        add_row(mk(FUNC_ADD, VALUE_MAX, 38, 0, 64'd1, 1, 1), 1'b1,
                res(0, 38, 1, ST_OVERFLOW));
        add_row(mk(FUNC_ADD, 64'd9, 1, 0, 64'd1, 1, 0), 1'b1,
                res(0, 1, 0, ST_OVERFLOW));
        add_row(mk(FUNC_CMP, 64'd10, 3, 1, 64'd1, 2, 0), 1'b0, '0);
        add_row(mk(FUNC_CMP, VALUE_MIN, 38, 0, VALUE_MAX, 38, 0), 1'b0, '0);
        add_row(mk(FUNC_DIV, -64'sd7, 10, 0, 64'd20, 5, 1), 1'b0, '0);
        add_row(mk(FUNC_MOD, -64'sd17, 10, 1, 64'd3, 5, 0), 1'b0, '0);
        add_row(mk(FUNC_MUL, VALUE_MIN, 19, 0, VALUE_NEG_ONE, 19, 0), 1'b0, '0);
        add_row(mk(FUNC_SUB, 64'd0, 38, 18, VALUE_MIN, 38, 18), 1'b0, '0);

        // Walk the directed table with no pop stalls
        foreach (directed[i])
            send_item(directed[i].item, directed[i].typed_in, directed[i].want);

        stall_phase = 1'b1;
        for (int n = 0; n < RAND_ITEMS; n++)
            send_item(random_item(), 1'b0, '0);
        push <= 1'b0;

        // Drain outstanding results
        drain = 0;
        while (pending_results.size() != 0 && drain < 50000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
